@@ rtl/bmg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared types and constants of the Box-Muller Gaussian pair pipeline.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int LOG_FRAC     = 26;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;
  localparam int ZW           = 32;
  localparam int TQ_W         = 23;
  localparam int SCALE_W      = 16;
  localparam int OUT_W        = 24;
  localparam int ROUND_SHIFT  = 39;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
  localparam logic [OUT_W-2:0] OUT_MAX = 23'h7FFFFF;

  typedef logic signed [CW-1:0] cordic_t;
  typedef logic signed [ZW-1:0] angle_t;

  localparam cordic_t CORDIC_K = 34'sd652032874;
  localparam angle_t  QUARTER_HALF = 32'sh2000_0000;

  localparam angle_t TURN_ATAN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
    32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
    32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
    32'sd10, 32'sd5, 32'sd3, 32'sd1
  };

  typedef struct packed {
    cordic_t c;
    cordic_t s;
  } trig_t;

endpackage

@@ rtl/bmg_log_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_log_cell
// One fraction bit of log2 by squaring the normalized mantissa.
// ----------------------------------------------------------------------------
module bmg_log_cell import bmg_pkg::*; #(
  parameter int EW = 6
) (
  input  logic                clk,
  input  logic                en,
  input  logic [30:0]         f_in,
  input  logic [LOG_FRAC-1:0] frac_in,
  input  logic [EW-1:0]       e_in,
  output logic [30:0]         f_out,
  output logic [LOG_FRAC-1:0] frac_out,
  output logic [EW-1:0]       e_out
);

  logic [61:0]         sq;
  logic [31:0]         f2;
  logic [30:0]         f_next;
  logic [LOG_FRAC-1:0] frac_next;

  always_comb begin
    sq = f_in * f_in;
    f2 = sq[61:30];
    // square reached 2 or more: bit is one, renormalize
    f_next = f2[31] ? f2[31:1] : f2[30:0];
    frac_next = {frac_in[LOG_FRAC-2:0], f2[31]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_out    <= f_next;
      frac_out <= frac_next;
      e_out    <= e_in;
    end
  end

endmodule

@@ rtl/bmg_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_sqrt_cell
// One result bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module bmg_sqrt_cell #(
  parameter int WW  = 47,
  parameter int RW  = 24,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WW-1:0] rem_in,
  input  logic [RW-1:0] q_in,
  output logic [WW-1:0] rem_out,
  output logic [RW-1:0] q_out
);

  logic [WW+1:0] trial;
  logic          ge;
  logic [WW-1:0] rem_next;
  logic [RW-1:0] q_next;

  always_comb begin
    trial = ((WW+2)'(q_in) << (BIT + 1)) + ((WW+2)'(1) << (2 * BIT));
    ge = {2'b00, rem_in} >= trial;
    rem_next = ge ? (rem_in - trial[WW-1:0]) : rem_in;
    q_next = q_in;
    q_next[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      q_out   <= q_next;
    end
  end

endmodule

@@ rtl/bmg_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_cordic_cell
// One CORDIC rotation step with a fixed shift and angle.
// ----------------------------------------------------------------------------
module bmg_cordic_cell import bmg_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic       clk,
  input  logic       en,
  input  cordic_t    x_in,
  input  cordic_t    y_in,
  input  angle_t     z_in,
  input  logic [1:0] q_in,
  output cordic_t    x_out,
  output cordic_t    y_out,
  output angle_t     z_out,
  output logic [1:0] q_out
);

  cordic_t xs;
  cordic_t ys;
  cordic_t x_next;
  cordic_t y_next;
  angle_t  z_next;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (!z_in[ZW-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - TURN_ATAN[SHIFT];
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + TURN_ATAN[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
      q_out <= q_in;
    end
  end

endmodule

@@ rtl/bmg_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_scale
// Multiplies radius, trig magnitude and scale, rounds, saturates and applies sign.
// ----------------------------------------------------------------------------
module bmg_scale import bmg_pkg::*; #(
  parameter int RW = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [RW-1:0]           radius,
  input  trig_t                   trig,
  input  logic [SCALE_W-1:0]      scale,
  output logic signed [OUT_W-1:0] gauss_cos,
  output logic signed [OUT_W-1:0] gauss_sin
);

  localparam int M1W = RW + TQ_W;
  localparam int H   = (M1W + 1) / 2;
  localparam int SW  = M1W + SCALE_W + 1;
  localparam int VW  = SW - ROUND_SHIFT;

  cordic_t                  tval [2];
  logic [M1W-1:0]           m1 [2];
  logic [1:0]               neg_a;
  logic [1:0]               neg_b;
  logic [H+SCALE_W-1:0]     p_lo [2];
  logic [M1W-H+SCALE_W-1:0] p_hi [2];
  logic [OUT_W-1:0]         res [2];

  assign tval[0] = trig.c;
  assign tval[1] = trig.s;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    cordic_t        mag;
    logic [CW:0]    rnd;
    logic [TQ_W-1:0] tq;
    logic [SW-1:0]  sum;
    logic [VW-1:0]  v;
    logic [OUT_W-2:0] vsat;
    logic [OUT_W-1:0] res_next;

    always_comb begin
      mag = tval[g][CW-1] ? -tval[g] : tval[g];
      rnd = {1'b0, mag} + (CW+1)'(128);
      tq = rnd[8 +: TQ_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m1[g]    <= M1W'(radius) * M1W'(tq);
        neg_a[g] <= tval[g][CW-1];
        p_lo[g]  <= (H+SCALE_W)'(m1[g][H-1:0]) * (H+SCALE_W)'(scale);
        p_hi[g]  <= (M1W-H+SCALE_W)'(m1[g][M1W-1:H]) * (M1W-H+SCALE_W)'(scale);
        neg_b[g] <= neg_a[g];
        res[g]   <= res_next;
      end
    end

    always_comb begin
      sum = (SW'(p_hi[g]) << H) + SW'(p_lo[g]) + (SW'(1) << (ROUND_SHIFT - 1));
      v = sum[SW-1:ROUND_SHIFT];
      vsat = (v > VW'(OUT_MAX)) ? OUT_MAX : v[OUT_W-2:0];
      res_next = neg_b[g] ? -{1'b0, vsat} : {1'b0, vsat};
    end
  end

  assign gauss_cos = res[0];
  assign gauss_sin = res[1];

endmodule

@@ rtl/box_muller_gaussian_pair.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_gaussian_pair
// Box-Muller transform: two uniform codes in, one Gaussian sample pair out.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   radius_uniform, angle_uniform
//   out      out  out_valid/out_ready gauss_cos, gauss_sin
//   cfg      in   cfg_wr_en           cfg_wr_data (std_scale)
//
// one item per clock while not stalled; the pipeline length is set by the log
// squaring cells and the square root cells, with input and scale registers.
// the cordic chain runs beside them and its result waits in a delay line.
// the whole chain advances when the output register is empty or taken.
// rst clears the valid bits and loads std_scale with 1.0.
// ----------------------------------------------------------------------------
module box_muller_gaussian_pair import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [UNIFORM_BITS-1:0] radius_uniform,
  input  logic [UNIFORM_BITS-1:0] angle_uniform,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] gauss_cos,
  output logic signed [OUT_W-1:0] gauss_sin,
  input  logic                    cfg_wr_en,
  input  logic [SCALE_W-1:0]      cfg_wr_data
);

  localparam int MW    = UNIFORM_BITS + 1;
  localparam int NW    = (MW > 31) ? MW : 31;
  localparam int EW    = $clog2(UNIFORM_BITS + 1);
  localparam int LW    = EW + LOG_FRAC;
  localparam int PW    = LW + 32;
  localparam int WW    = PW - 17;
  localparam int RW    = (WW + 1) / 2;
  localparam int DLY   = LOG_FRAC + 1 + RW - CORDIC_STEPS;
  localparam int TOTAL = 1 + LOG_FRAC + 1 + RW + 3;

  logic               en;
  logic [TOTAL-1:0]   vld;
  logic [SCALE_W-1:0] std_scale;

  assign en        = !vld[TOTAL-1] || out_ready;
  assign in_ready  = en && !rst;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      std_scale <= SCALE_RESET;
    end else begin
      if (en) begin
        vld <= {vld[TOTAL-2:0], in_valid};
      end
      if (cfg_wr_en) begin
        std_scale <= cfg_wr_data;
      end
    end
  end

  // radius front end: normalize m = k1 + 1 to Q1.30
  logic [MW-1:0] m;
  logic [EW-1:0] e_comb;
  logic [NW-1:0] norm;
  logic [UNIFORM_BITS-1:0] p;
  logic [31:0] ph;
  logic [31:0] t;

  always_comb begin
    m = {1'b0, radius_uniform} + MW'(1);
    e_comb = '0;
    for (int i = 0; i < MW; i++) begin
      if (m[i]) begin
        e_comb = EW'(i);
      end
    end
    norm = NW'(m) << (EW'(NW - 1) - e_comb);
  end

  assign p = angle_uniform + UNIFORM_BITS'(1);

  if (UNIFORM_BITS >= 32) begin : g_ph_wide
    assign ph = p[UNIFORM_BITS-1 -: 32];
  end else begin : g_ph_narrow
    assign ph = {p, {(32 - UNIFORM_BITS){1'b0}}};
  end

  assign t = ph + 32'h2000_0000;

  logic [30:0]         log_f    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] log_frac [LOG_FRAC+1];
  logic [EW-1:0]       log_e    [LOG_FRAC+1];
  angle_t              z0;
  logic [1:0]          q0;

  always_ff @(posedge clk) begin
    if (en) begin
      log_f[0]    <= norm[NW-1 -: 31];
      log_frac[0] <= '0;
      log_e[0]    <= e_comb;
      z0          <= angle_t'({2'b00, t[29:0]}) - QUARTER_HALF;
      q0          <= t[31:30];
    end
  end

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
    bmg_log_cell #(.EW(EW)) u_cell (
      .clk      (clk),
      .en       (en),
      .f_in     (log_f[i]),
      .frac_in  (log_frac[i]),
      .e_in     (log_e[i]),
      .f_out    (log_f[i+1]),
      .frac_out (log_frac[i+1]),
      .e_out    (log_e[i+1])
    );
  end

  // -2 ln u1 = L * ln2 * 2, kept with 40 fraction bits
  logic [EW-1:0] de;
  logic [LW-1:0] lg;
  logic [PW-1:0] prod;
  logic [WW-1:0] sq_rem [RW+1];
  logic [RW-1:0] sq_q   [RW+1];

  always_comb begin
    de   = EW'(UNIFORM_BITS) - log_e[LOG_FRAC];
    lg   = {de, {LOG_FRAC{1'b0}}} - LW'(log_frac[LOG_FRAC]);
    prod = PW'(lg) * PW'(LN2_Q32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= prod[PW-1:17];
      sq_q[0]   <= '0;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    bmg_sqrt_cell #(.WW(WW), .RW(RW), .BIT(RW - 1 - i)) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (sq_rem[i]),
      .q_in    (sq_q[i]),
      .rem_out (sq_rem[i+1]),
      .q_out   (sq_q[i+1])
    );
  end

  // angle path
  cordic_t    cx [CORDIC_STEPS+1];
  cordic_t    cy [CORDIC_STEPS+1];
  angle_t     cz [CORDIC_STEPS+1];
  logic [1:0] cq [CORDIC_STEPS+1];

  assign cx[0] = CORDIC_K;
  assign cy[0] = '0;
  assign cz[0] = z0;
  assign cq[0] = q0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    bmg_cordic_cell #(.SHIFT(i)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .q_in  (cq[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1]),
      .q_out (cq[i+1])
    );
  end

  trig_t trig_map;
  trig_t trig_dly [DLY];

  always_comb begin
    case (cq[CORDIC_STEPS])
      2'd0: begin
        trig_map.c = cx[CORDIC_STEPS];
        trig_map.s = cy[CORDIC_STEPS];
      end
      2'd1: begin
        trig_map.c = -cy[CORDIC_STEPS];
        trig_map.s = cx[CORDIC_STEPS];
      end
      2'd2: begin
        trig_map.c = -cx[CORDIC_STEPS];
        trig_map.s = -cy[CORDIC_STEPS];
      end
      default: begin
        trig_map.c = cy[CORDIC_STEPS];
        trig_map.s = -cx[CORDIC_STEPS];
      end
    endcase
  end

  // hold trig results until the radius catches up
  always_ff @(posedge clk) begin
    if (en) begin
      trig_dly[0] <= trig_map;
      for (int i = 1; i < DLY; i++) begin
        trig_dly[i] <= trig_dly[i-1];
      end
    end
  end

  bmg_scale #(.RW(RW)) u_scale (
    .clk       (clk),
    .en        (en),
    .radius    (sq_q[RW]),
    .trig      (trig_dly[DLY-1]),
    .scale     (std_scale),
    .gauss_cos (gauss_cos),
    .gauss_sin (gauss_sin)
  );

endmodule
